// File: hdl/lgst_pkg.sv
// Shared types, codes and constants of the light gun sense timing block.
package lgst_pkg;

  // Item kinds carried in the func field.
  localparam logic [1:0] FUNC_UPDATE = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_SCAN   = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_DIVIDER = 1'b0;
  localparam logic REG_ADJUST  = 1'b1;

  // Port bit layout and fixed values.
  localparam logic [6:0]  PORT_RESET = 7'h4C;
  localparam logic [6:0]  READ_MASK  = 7'h7C;
  localparam int          BIT_LIGHT  = 6;
  localparam int          BIT_START  = 5;
  localparam int          BIT_TRIG   = 4;
  localparam logic [1:0]  PORT_FIXED = 2'b11;
  localparam logic [31:0] COUNT_IDLE = 32'h7FFF_FFFF;
  localparam logic signed [15:0] OFF_AIM = -16'sd16384;

  // Widths of internal values.
  localparam int NUM_W  = 20;  // light delay numerator (aim_x + adjust) * 4
  localparam int SHOT_W = 25;  // shot window accumulator
  localparam int DCNT_W = $clog2(NUM_W);

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] pointer_x;
    logic signed [15:0] pointer_y;
    logic               trigger_button;
    logic               start_button;
    logic               offscreen_button;
    logic [23:0]        elapsed_units;
    logic [31:0]        timestamp;
    logic [7:0]         bus_out;
    logic [7:0]         bus_driven_mask;
    logic [9:0]         scan_line;
  } in_word_t;

  typedef struct packed {
    logic [6:0] port_data;
    logic       light_seen;
    logic       shot_active;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted input word
    logic exec;       // apply the item to the port state
    logic div_start;  // launch the light delay division
    logic commit;     // arm the light delay with the quotient
    logic out_load;   // move the result into the output register
  } lgst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic arm;        // scanline hit that needs a light delay
    logic div_busy;
    logic div_done;
  } lgst_sts_t;

endpackage

// File: hdl/lgst_div.sv
// Restoring divider that computes the light delay, one quotient bit per cycle.
module lgst_div
  import lgst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [15:0]      divisor,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [15:0]       dvs_r, dvs_nxt;
  logic [16:0]       trial;
  logic [16:0]       diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[NUM_W-1]};
    diff     = trial - {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[16]) begin
        rem_nxt = diff[15:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hdl/lgst_dp.sv
// Datapath: port state, shot window, light countdown and result register.
module lgst_dp
  import lgst_pkg::*;
#(
  parameter int SHOT_DURATION = 250000,
  parameter int LIGHT_PULSE   = 16,
  parameter int X_LIMIT       = 21472
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lgst_cmd_t          cmd,
  output lgst_sts_t          sts,
  input  in_word_t           in_data,
  input  logic [15:0]        pixel_divider,
  input  logic signed [15:0] coord_adjust,
  output out_word_t          out_data
);

  localparam logic [SHOT_W-1:0] SHOT_END   = SHOT_W'(SHOT_DURATION);
  localparam logic [SHOT_W-1:0] SHOT_THIRD = SHOT_W'(SHOT_DURATION / 3);
  localparam logic [SHOT_W-1:0] SHOT_TWO3  = SHOT_W'(SHOT_DURATION * 2 / 3);
  localparam logic [31:0]       PULSE_LEN  = 32'(LIGHT_PULSE);
  localparam logic [15:0]       X_END      = 16'(X_LIMIT);

  in_word_t           item_r;
  logic [6:0]         port_r, port_nxt;
  logic               phase_done_r, phase_done_nxt;
  logic [31:0]        countdown_r, countdown_nxt;
  logic [31:0]        last_time_r, last_time_nxt;
  logic               shot_run_r, shot_run_nxt;
  logic [SHOT_W-1:0]  shot_cnt_r, shot_cnt_nxt;
  logic               prev_shot_r, prev_shot_nxt;
  logic signed [15:0] aim_x_r, aim_x_nxt;
  logic signed [15:0] aim_y_r, aim_y_nxt;
  logic [6:0]         pdata_r, pdata_nxt;
  out_word_t          out_r;

  logic [31:0]        cd_sub;
  logic               expired;
  logic [6:0]         tk_port;
  logic               tk_phase;
  logic [31:0]        tk_cd;
  logic [SHOT_W-1:0]  shot_sum;
  logic signed [17:0] dy;
  logic signed [17:0] xsum;
  logic [NUM_W-1:0]   num;
  logic [15:0]        div_eff;
  logic               near, x_ok, big_enough;
  logic [6:0]         mask7;
  logic               div_busy, div_done;
  logic [NUM_W-1:0]   quotient;

  // Light countdown advance shared by bus reads and scanline events.
  always_comb begin
    cd_sub   = countdown_r - (item_r.timestamp - last_time_r);
    expired  = (cd_sub == 32'd0) || cd_sub[31];
    tk_port  = port_r;
    tk_phase = phase_done_r;
    tk_cd    = cd_sub;
    if (expired) begin
      if (!phase_done_r) begin
        tk_port[BIT_LIGHT] = 1'b0;
        tk_phase           = 1'b1;
        tk_cd              = PULSE_LEN;
      end else begin
        tk_port[BIT_LIGHT] = 1'b1;
        tk_cd              = COUNT_IDLE;
      end
    end
  end

  // Scanline hit test and light delay numerator.
  always_comb begin
    dy      = $signed({{2{aim_y_r[15]}}, aim_y_r}) - $signed({8'b0, item_r.scan_line});
    near    = (dy >= -18'sd1) && (dy <= 18'sd1);
    x_ok    = !aim_x_r[15] && ($unsigned(aim_x_r) < X_END);
    xsum    = $signed({{2{aim_x_r[15]}}, aim_x_r})
            + $signed({{2{coord_adjust[15]}}, coord_adjust});
    num     = {xsum, 2'b00};
    div_eff = (pixel_divider == 16'd0) ? 16'd1 : pixel_divider;
    big_enough = $signed(num) >= $signed({4'b0000, div_eff});
  end

  assign shot_sum = shot_cnt_r + SHOT_W'(item_r.elapsed_units);
  assign mask7    = item_r.bus_driven_mask[6:0];

  always_comb begin
    port_nxt       = port_r;
    phase_done_nxt = phase_done_r;
    countdown_nxt  = countdown_r;
    last_time_nxt  = last_time_r;
    shot_run_nxt   = shot_run_r;
    shot_cnt_nxt   = shot_cnt_r;
    prev_shot_nxt  = prev_shot_r;
    aim_x_nxt      = aim_x_r;
    aim_y_nxt      = aim_y_r;
    pdata_nxt      = pdata_r;
    if (cmd.exec) begin
      pdata_nxt = 7'd0;
      case (item_r.func)
        FUNC_UPDATE: begin
          aim_x_nxt = item_r.pointer_x;
          aim_y_nxt = item_r.pointer_y;
          port_nxt  = {port_r[BIT_LIGHT], !item_r.start_button,
                       !item_r.trigger_button, PORT_FIXED, 2'b00};
          if (shot_run_r) begin
            shot_cnt_nxt = shot_sum;
            if (shot_sum >= SHOT_END) begin
              shot_run_nxt = 1'b0;
              shot_cnt_nxt = '0;
            end else begin
              aim_x_nxt = OFF_AIM;
              aim_y_nxt = OFF_AIM;
              // Trigger reads released, pressed, then released.
              port_nxt[BIT_TRIG] = (shot_sum >= SHOT_TWO3) || (shot_sum < SHOT_THIRD);
            end
          end else if (item_r.offscreen_button && !prev_shot_r) begin
            shot_run_nxt = 1'b1;
            shot_cnt_nxt = '0;
          end
          prev_shot_nxt = item_r.offscreen_button;
        end
        FUNC_READ: begin
          port_nxt       = tk_port;
          phase_done_nxt = tk_phase;
          countdown_nxt  = tk_cd;
          last_time_nxt  = item_r.timestamp;
          pdata_nxt      = ((item_r.bus_out[6:0] & mask7) | (tk_port & ~mask7)) & READ_MASK;
        end
        FUNC_SCAN: begin
          port_nxt       = tk_port;
          phase_done_nxt = tk_phase;
          countdown_nxt  = tk_cd;
          last_time_nxt  = item_r.timestamp;
        end
        default: begin
          pdata_nxt = 7'd0;
        end
      endcase
    end
    if (cmd.commit) begin
      port_nxt[BIT_LIGHT] = 1'b1;
      phase_done_nxt      = 1'b0;
      countdown_nxt       = 32'(quotient);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_r       <= PORT_RESET;
      phase_done_r <= 1'b1;
      countdown_r  <= COUNT_IDLE;
      last_time_r  <= 32'd0;
      shot_run_r   <= 1'b0;
      shot_cnt_r   <= '0;
      prev_shot_r  <= 1'b0;
      aim_x_r      <= 16'sd0;
      aim_y_r      <= 16'sd0;
    end else begin
      port_r       <= port_nxt;
      phase_done_r <= phase_done_nxt;
      countdown_r  <= countdown_nxt;
      last_time_r  <= last_time_nxt;
      shot_run_r   <= shot_run_nxt;
      shot_cnt_r   <= shot_cnt_nxt;
      prev_shot_r  <= prev_shot_nxt;
      aim_x_r      <= aim_x_nxt;
      aim_y_r      <= aim_y_nxt;
    end
    pdata_r <= pdata_nxt;
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.out_load) begin
      out_r.port_data   <= pdata_r;
      out_r.light_seen  <= !port_r[BIT_LIGHT];
      out_r.shot_active <= shot_run_r;
    end
  end

  lgst_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (num),
    .divisor  (div_eff),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  assign sts.arm      = (item_r.func == FUNC_SCAN) && near && x_ok && big_enough;
  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign out_data     = out_r;

endmodule

// File: hdl/lgst_ctrl.sv
// Controller: sequences one item through execute, optional division and output.
module lgst_ctrl
  import lgst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output lgst_cmd_t cmd,
  input  lgst_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.arm) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: hdl/light_gun_sense_timing_top.sv
// Top level of the light gun sense timing block: ports, registers, assertions.
//
//  Channel  Handshake            Payload      Direction
//  in       in_valid / in_stall  in_data      one word per item, into the block
//  out      out_valid/ out_stall out_data     one result word per item
//  cfg      cfg_psel..cfg_pready cfg_pwdata   register writes and reads (APB)
//
// An input update, a bus read or a scanline event that arms nothing passes through
// capture, execute, and a load into the output register before the next word can
// be accepted; the load waits while an earlier result word is still stalled.
// A scanline event that arms the light delay also waits for the 20-step
// restoring divider that turns the aim numerator into a delay.
// Reset is synchronous and active low; it restores the port bits to 0x4C, an
// idle countdown and no shot window, with a divider of one and no adjust.
// A result word waits in the output register while out_stall is high; the
// block takes the next item meanwhile and holds its result until that frees.
module light_gun_sense_timing_top
  import lgst_pkg::*;
#(
  parameter int SHOT_DURATION = 250000,
  parameter int LIGHT_PULSE   = 16,
  parameter int X_LIMIT       = 21472
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers. Register 0 sits at byte address 0 and register 1
  // at byte address 4, so address bit 2 selects between them.
  logic [15:0]        divider_r, divider_nxt;
  logic signed [15:0] adjust_r, adjust_nxt;
  logic               cfg_wr;
  logic               cfg_sel;

  lgst_cmd_t cmd;
  lgst_sts_t sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_paddr[2];

  always_comb begin
    divider_nxt = divider_r;
    adjust_nxt  = adjust_r;
    if (cfg_wr) begin
      case (cfg_sel)
        REG_DIVIDER: divider_nxt = cfg_pwdata[15:0];
        REG_ADJUST:  adjust_nxt  = $signed(cfg_pwdata[15:0]);
        default:     divider_nxt = divider_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divider_r <= 16'd1;
      adjust_r  <= 16'sd0;
    end else begin
      divider_r <= divider_nxt;
      adjust_r  <= adjust_nxt;
    end
  end

  assign cfg_prdata = (cfg_sel == REG_ADJUST) ? {16'd0, adjust_r} : {16'd0, divider_r};

  // The controller steps each word through its phases; the datapath holds all
  // port state and the divider, and moves only on the controller's commands.
  lgst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  lgst_dp #(
    .SHOT_DURATION (SHOT_DURATION),
    .LIGHT_PULSE   (LIGHT_PULSE),
    .X_LIMIT       (X_LIMIT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_data       (in_data),
    .pixel_divider (divider_r),
    .coord_adjust  (adjust_r),
    .out_data      (out_data)
  );

  // An accepted word keeps the block busy on the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted but block not busy afterwards");

  // A new result word appears only at the end of an item in progress.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without an item in progress");

  // The divider never runs while the block is waiting for a new word.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !sts.div_busy)
    else $error("divider busy while block idle");

  // A division is started only for a scanline event that hits.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> sts.arm && cmd.exec)
    else $error("division started without a scanline hit");

endmodule

// File: test/light_gun_sense_timing_top_tb.sv
// Self-checking testbench of the light gun sense timing block.
`timescale 1ns / 100ps

module light_gun_sense_timing_top_tb
  import lgst_pkg::*;
();

  localparam int SHOT_TIME   = 250000;
  localparam int PULSE_LEN   = 16;
  localparam int X_EDGE      = 21472;
  localparam int PHASE_ITEMS = 75;
  localparam int DRAIN       = 30;
  localparam int LIMIT       = 200000;

  // The package names three item kinds; the fourth code must leave the port untouched.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  light_gun_sense_timing_top #(
    .SHOT_DURATION(SHOT_TIME),
    .LIGHT_PULSE  (PULSE_LEN),
    .X_LIMIT      (X_EDGE)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #1 clk = ~clk;

  // Words waiting to be driven, and the result words predicted for accepted ones.
  in_word_t  item_q[$];
  out_word_t expected_words[$];
  int        errors = 0;

  // Predicted port state, kept at reset values until the first accepted word.
  logic [6:0]         gun_bits = PORT_RESET;
  bit                 gun_pulse_done = 1'b1;
  logic [31:0]        gun_count = COUNT_IDLE;
  logic [31:0]        gun_last_ts = '0;
  bit                 win_run = 1'b0;
  logic [31:0]        win_acc = '0;
  bit                 win_prev_btn = 1'b0;
  int                 aim_h = 0;
  int                 aim_v = 0;
  logic [15:0]        div_reg = 16'd1;
  logic signed [15:0] adj_reg = 16'sd0;

  // Advance the light countdown to the given time. An expired countdown either
  // starts the low pulse of the sense bit (when a delay was armed) or ends it.
  task automatic sense_tick(input logic [31:0] ts);
    gun_count   = gun_count - (ts - gun_last_ts);
    gun_last_ts = ts;
    if (gun_count == 32'd0 || gun_count[31]) begin
      if (!gun_pulse_done) begin
        gun_bits[BIT_LIGHT] = 1'b0;
        gun_pulse_done      = 1'b1;
        gun_count           = 32'(PULSE_LEN);
      end else begin
        gun_bits[BIT_LIGHT] = 1'b1;
        gun_count           = COUNT_IDLE;
      end
    end
  endtask

  // Apply one accepted word to the predicted state and form its result word.
  task automatic predict_port_word(input in_word_t w, output out_word_t r);
    int dy;
    int num;
    int dv;
    r = '0;
    case (w.func)
      FUNC_UPDATE: begin
        aim_h    = w.pointer_x;
        aim_v    = w.pointer_y;
        gun_bits = {gun_bits[BIT_LIGHT], ~w.start_button, ~w.trigger_button, PORT_FIXED, 2'b00};
        if (win_run) begin
          win_acc = win_acc + 32'(w.elapsed_units);
          if (win_acc >= 32'(SHOT_TIME)) begin
            win_run = 1'b0;
            win_acc = '0;
          end else begin
            // Inside the window the gun points offscreen and the trigger pulses
            // in the middle third.
            aim_h = OFF_AIM;
            aim_v = OFF_AIM;
            if (win_acc >= 32'(SHOT_TIME * 2 / 3)) begin
              gun_bits[BIT_TRIG] = 1'b1;
            end else if (win_acc >= 32'(SHOT_TIME / 3)) begin
              gun_bits[BIT_TRIG] = 1'b0;
            end else begin
              gun_bits[BIT_TRIG] = 1'b1;
            end
          end
        end else if (w.offscreen_button && !win_prev_btn) begin
          win_run = 1'b1;
          win_acc = '0;
        end
        win_prev_btn = w.offscreen_button;
      end
      FUNC_READ: begin
        sense_tick(w.timestamp);
        r.port_data = ((w.bus_out[6:0] & w.bus_driven_mask[6:0]) |
                       (gun_bits & ~w.bus_driven_mask[6:0])) & READ_MASK;
      end
      FUNC_SCAN: begin
        sense_tick(w.timestamp);
        dy = aim_v - int'(w.scan_line);
        if (dy >= -1 && dy <= 1 && aim_h >= 0 && aim_h < X_EDGE) begin
          num = (aim_h + int'(adj_reg)) * 4;
          dv  = (div_reg == 16'd0) ? 1 : int'(div_reg);
          // A delay shorter than one unit arms nothing.
          if (num >= dv) begin
            gun_bits[BIT_LIGHT] = 1'b1;
            gun_pulse_done      = 1'b0;
            gun_count           = 32'(num / dv);
          end
        end
      end
      default: begin
      end
    endcase
    r.light_seen  = ~gun_bits[BIT_LIGHT];
    r.shot_active = win_run;
  endtask

  // Sender: presents queued words and predicts each one as it is accepted.
  // The gap before each word is drawn anew; bursts without gaps come and go.
  int tx_wait = 0;
  bit tx_burst = 1'b0;

  always @(posedge clk) begin : drive_proc
    int        gap;
    out_word_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait  <= 0;
    end else if (in_valid && !in_stall) begin
      predict_port_word(in_data, res);
      expected_words.push_back(res);
      gap = tx_burst ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
      if (gap == 0 && item_q.size() != 0) begin
        in_data <= item_q.pop_front();
      end else begin
        in_valid <= 1'b0;
        tx_wait  <= gap;
      end
    end else if (!in_valid) begin
      if (tx_wait != 0) begin
        tx_wait <= tx_wait - 1;
      end else if (item_q.size() != 0) begin
        in_data  <= item_q.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Receiver: checks every accepted result word against the oldest prediction,
  // then holds off the next one for a drawn number of cycles.
  int rx_wait = 0;
  bit rx_burst = 1'b0;

  always @(posedge clk) begin : watch_proc
    out_word_t want;
    int        n;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word %h arrived with none expected", $time, out_data);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (out_data.port_data !== want.port_data) begin
            $display("%0t: port_data expected %h actual %h",
                     $time, want.port_data, out_data.port_data);
            errors++;
          end
          if (out_data.light_seen !== want.light_seen) begin
            $display("%0t: light_seen expected %b actual %b",
                     $time, want.light_seen, out_data.light_seen);
            errors++;
          end
          if (out_data.shot_active !== want.shot_active) begin
            $display("%0t: shot_active expected %b actual %b",
                     $time, want.shot_active, out_data.shot_active);
            errors++;
          end
        end
        n = rx_burst ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        out_stall <= (n != 0);
        rx_wait   <= n;
      end else if (rx_wait != 0) begin
        rx_wait   <= rx_wait - 1;
        out_stall <= (rx_wait > 1);
      end
    end
  end

  // A word with every field random; the builders below override what matters.
  function automatic in_word_t noise_word();
    in_word_t w;
    w.func             = 2'($urandom_range(0, 3));
    w.pointer_x        = 16'($urandom);
    w.pointer_y        = 16'($urandom);
    w.trigger_button   = 1'($urandom);
    w.start_button     = 1'($urandom);
    w.offscreen_button = 1'($urandom);
    w.elapsed_units    = 24'($urandom);
    w.timestamp        = $urandom;
    w.bus_out          = 8'($urandom);
    w.bus_driven_mask  = 8'($urandom);
    w.scan_line        = 10'($urandom);
    return w;
  endfunction

  function automatic in_word_t update_word(int x, int y, bit trig, bit start, bit shot,
                                           logic [23:0] el);
    in_word_t w;
    w                  = noise_word();
    w.func             = FUNC_UPDATE;
    w.pointer_x        = 16'(x);
    w.pointer_y        = 16'(y);
    w.trigger_button   = trig;
    w.start_button     = start;
    w.offscreen_button = shot;
    w.elapsed_units    = el;
    return w;
  endfunction

  function automatic in_word_t read_word(logic [31:0] ts, logic [7:0] drv, logic [7:0] msk);
    in_word_t w;
    w                 = noise_word();
    w.func            = FUNC_READ;
    w.timestamp       = ts;
    w.bus_out         = drv;
    w.bus_driven_mask = msk;
    return w;
  endfunction

  function automatic in_word_t scan_word(logic [31:0] ts, int ln);
    in_word_t w;
    w           = noise_word();
    w.func      = FUNC_SCAN;
    w.timestamp = ts;
    w.scan_line = 10'(ln);
    return w;
  endfunction

  // Write one register, read it back and compare the implemented 16 bits.
  task automatic reg_write_verify(input logic [2:0] addr, input logic [15:0] val);
    logic [31:0] rb;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= {{16{val[15]}}, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rb = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rb[15:0] !== val) begin
      $display("%0t: register at %0d expected %h actual %h", $time, addr, val, rb[15:0]);
      errors++;
    end
  endtask

  task automatic set_config(input logic [15:0] dv, input logic [15:0] av);
    reg_write_verify({REG_DIVIDER, 2'b00}, dv);
    reg_write_verify({REG_ADJUST, 2'b00}, av);
    div_reg = dv;
    adj_reg = av;
    @(negedge clk);
  endtask

  // Sampled on the falling edge so that the driver's updates of the same
  // rising edge are complete; every word yields a result, so an empty
  // prediction store means the block is idle.
  task automatic wait_idle();
    while (item_q.size() != 0 || in_valid || expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  logic [31:0] gen_ts = 32'd100;

  // One random phase: mostly aim-and-scan sequences that arm a delay and read
  // around its expiry, some complete shot windows, and single noise words.
  task automatic fill_random_phase();
    int x;
    int y;
    int ln;
    int d;
    int k;
    int dv;
    in_word_t w;
    while (item_q.size() < PHASE_ITEMS) begin
      k = $urandom_range(0, 9);
      if (k <= 4) begin
        case ($urandom_range(0, 5))
          0:       x = X_EDGE - 1;
          1:       x = $urandom_range(0, 40);
          2:       x = X_EDGE;
          default: x = $urandom_range(0, X_EDGE - 1);
        endcase
        y = $urandom_range(0, 1023);
        // A long elapsed time closes any open shot window, so the aim sticks.
        item_q.push_back(update_word(x, y, 1'($urandom), 1'($urandom), 1'b0,
                                     24'($urandom_range(SHOT_TIME, 24'hFF_FFFF))));
        ln = y + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 4) == 0) ln = $urandom_range(0, 1023);
        if (ln < 0) ln = 0;
        if (ln > 1023) ln = 1023;
        gen_ts = gen_ts + $urandom_range(1, 2000);
        item_q.push_back(scan_word(gen_ts, ln));
        dv = (div_reg == 16'd0) ? 1 : int'(div_reg);
        d  = (x + int'(adj_reg)) * 4 / dv;
        if (d < 1) d = $urandom_range(1, 30);
        gen_ts = gen_ts + d - 2 + $urandom_range(0, 2);
        repeat ($urandom_range(2, 5)) begin
          if ($urandom_range(0, 3) == 0) begin
            item_q.push_back(scan_word(gen_ts, $urandom_range(0, 1023)));
          end else begin
            item_q.push_back(read_word(gen_ts, 8'($urandom), 8'($urandom)));
          end
          gen_ts = gen_ts + $urandom_range(1, 10);
        end
      end else if (k <= 6) begin
        item_q.push_back(update_word($urandom, $urandom, 1'($urandom), 1'($urandom), 1'b0,
                                     24'(SHOT_TIME)));
        item_q.push_back(update_word($urandom, $urandom, 1'($urandom), 1'($urandom), 1'b1,
                                     24'($urandom_range(0, 50000))));
        repeat ($urandom_range(2, 6)) begin
          item_q.push_back(update_word($urandom, $urandom, 1'($urandom), 1'($urandom),
                                       1'($urandom), 24'($urandom_range(20000, 90000))));
          if ($urandom_range(0, 1) == 0) begin
            gen_ts = gen_ts + $urandom_range(1, 100);
            item_q.push_back(read_word(gen_ts, 8'($urandom), 8'($urandom)));
          end
        end
        item_q.push_back(update_word($urandom, $urandom, 1'($urandom), 1'($urandom), 1'b0,
                                     24'(SHOT_TIME)));
      end else begin
        w = noise_word();
        if ($urandom_range(0, 1) == 0) begin
          gen_ts      = gen_ts + $urandom_range(0, 100);
          w.timestamp = gen_ts;
        end
        item_q.push_back(w);
      end
    end
  endtask

  int unsigned cycle_cnt;

  // Watchdog: far beyond the slowest correct run.
  initial begin
    for (cycle_cnt = 0; cycle_cnt < LIMIT; cycle_cnt++) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // Phases of register settings, the extremes of both registers among them.
  logic [15:0] phase_div[6] = '{16'hFFFF, 16'h0000, 16'd3, 16'd1, 16'd9, 16'd1};
  logic [15:0] phase_adj[6] = '{16'h7FFF, 16'h8000, 16'hFF9C, 16'h7FFF, 16'd2000, 16'd0};

  initial begin
    logic [31:0] t;
    in_word_t    unused_w;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words under the reset settings: unused code, bus merge extremes,
    // aim extremes, a zero delay, the longest delay with its expiry and pulse
    // end, the right edge of the screen, a hit one line off, a whole shot
    // window with a press ignored inside it, and a timestamp that wraps.
    unused_w      = noise_word();
    unused_w.func = FUNC_UNUSED;
    item_q.push_back(unused_w);
    item_q.push_back(read_word(32'd0, 8'hFF, 8'h00));
    item_q.push_back(update_word(-32768, 32767, 1'b1, 1'b1, 1'b0, 24'd0));
    item_q.push_back(read_word(32'd10, 8'hFF, 8'hFF));
    item_q.push_back(read_word(32'd20, 8'h00, 8'hFF));
    item_q.push_back(read_word(32'd30, 8'hA5, 8'h0F));
    item_q.push_back(update_word(0, 0, 1'b0, 1'b0, 1'b0, 24'd0));
    item_q.push_back(scan_word(32'd100, 0));
    item_q.push_back(update_word(X_EDGE - 1, 1023, 1'b0, 1'b1, 1'b0, 24'hFF_FFFF));
    item_q.push_back(scan_word(32'd1000, 1023));
    t = 32'd1000 + 32'((X_EDGE - 1) * 4);
    item_q.push_back(read_word(t - 32'd1, 8'h00, 8'h00));
    item_q.push_back(read_word(t, 8'h00, 8'h00));
    item_q.push_back(scan_word(t + 32'd10, 5));
    item_q.push_back(read_word(t + 32'd16, 8'h00, 8'h00));
    item_q.push_back(update_word(X_EDGE, 5, 1'b1, 1'b0, 1'b0, 24'd7));
    item_q.push_back(scan_word(t + 32'd100, 5));
    item_q.push_back(update_word(1, -1, 1'b0, 1'b0, 1'b0, 24'd1));
    item_q.push_back(scan_word(t + 32'd200, 0));
    item_q.push_back(read_word(t + 32'd204, 8'h00, 8'h00));
    item_q.push_back(update_word(100, 100, 1'b0, 1'b0, 1'b1, 24'd0));
    item_q.push_back(update_word(100, 100, 1'b0, 1'b0, 1'b1, 24'(SHOT_TIME / 3)));
    item_q.push_back(update_word(100, 100, 1'b0, 1'b0, 1'b0, 24'(SHOT_TIME / 3)));
    item_q.push_back(update_word(100, 100, 1'b1, 1'b1, 1'b1, 24'hFF_FFFF));
    item_q.push_back(update_word(100, 100, 1'b1, 1'b1, 1'b1, 24'd0));
    item_q.push_back(read_word(32'hFFFF_FFF0, 8'h00, 8'h00));
    item_q.push_back(read_word(32'd5, 8'h00, 8'h00));
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      set_config(phase_div[p], phase_adj[p]);
      fill_random_phase();
      wait_idle();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/lgst_pkg.sv
hdl/lgst_div.sv
hdl/lgst_dp.sv
hdl/lgst_ctrl.sv
hdl/light_gun_sense_timing_top.sv
test/light_gun_sense_timing_top_tb.sv
